@@ rtl/core/mcsm_pkg.sv @@
// Shared types and constants for the maze carver by set merging.
// Used by mcsm_ctrl and by the top level; no dependencies of its own.
package mcsm_pkg;

   // Stream word layout
   localparam int REQ_TDATA_W = 24;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 16;

   // Field widths
   localparam int COORD_W  = 3;
   localparam int GRID_W   = 5;
   localparam int REMAIN_W = 6;
   localparam int ENTRY_W  = 7;

   // Entry codes
   localparam int PATH_CODE   = 0;
   localparam int WALL_CODE   = 1;
   localparam int FIRST_LABEL = 2;

   typedef enum logic [1:0] {
      ACT_INIT  = 2'd0,
      ACT_CARVE = 2'd1,
      ACT_READ  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      DIR_ROW_PLUS  = 2'd0,
      DIR_COL_PLUS  = 2'd1,
      DIR_ROW_MINUS = 2'd2,
      DIR_COL_MINUS = 2'd3
   } dir_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INIT,
      ST_RD_OWN,
      ST_RD_OTHER,
      ST_CMP,
      ST_WALL,
      ST_SCAN,
      ST_ENT0,
      ST_ENT1,
      ST_RD_ENTRY,
      ST_RD_CAP,
      ST_RESP
   } state_type;

endpackage

@@ rtl/core/mcsm_grid_ram.sv @@
// Grid label store: one write port, one read port with registered read data.
// Standalone; sized by its parameters.
module mcsm_grid_ram #(
   parameter int DEPTH = 289,
   parameter int AW    = 9,
   parameter int LW    = 7
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [LW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [LW-1:0] rd_data
);

   logic [LW-1:0] mem_ff [DEPTH];
   logic [LW-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/mcsm_ctrl.sv @@
// Sequencer for the maze carver: decodes words, sweeps the grid store, and
// drives the shared address unit and label comparator. Depends on mcsm_pkg.
module mcsm_ctrl #(
   parameter int CELLS_PER_SIDE = 8,
   parameter int AW             = 9,
   parameter int LW             = 7
) (
   input  logic                           clock,
   input  logic                           reset,
   // request word
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_action,
   input  logic [mcsm_pkg::COORD_W-1:0]   req_cell_row,
   input  logic [mcsm_pkg::COORD_W-1:0]   req_cell_col,
   input  logic [1:0]                     req_direction,
   input  logic [mcsm_pkg::GRID_W-1:0]    req_grid_row,
   input  logic [mcsm_pkg::GRID_W-1:0]    req_grid_col,
   // response word
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_carved,
   output logic [mcsm_pkg::REMAIN_W-1:0]  rsp_remaining,
   output logic                           rsp_done_res,
   output logic [mcsm_pkg::ENTRY_W-1:0]   rsp_entry_value,
   output logic                           rsp_is_wall,
   // grid store
   output logic                           ram_wr_en,
   output logic [AW-1:0]                  ram_wr_addr,
   output logic [LW-1:0]                  ram_wr_data,
   output logic [AW-1:0]                  ram_rd_addr,
   input  logic [LW-1:0]                  ram_rd_data
);
   import mcsm_pkg::*;

   localparam int GSIDE = 2 * CELLS_PER_SIDE + 1;
   localparam int NENT  = GSIDE * GSIDE;
   localparam int RW    = $clog2(GSIDE);
   localparam int MW    = $clog2(CELLS_PER_SIDE * CELLS_PER_SIDE);

   localparam logic [AW-1:0] GSIDE_A = AW'(GSIDE);
   localparam logic [AW-1:0] LAST_A  = AW'(NENT - 1);
   localparam logic [AW-1:0] NENT_A  = AW'(NENT);
   localparam logic [AW-1:0] ENT0_A  = AW'(CELLS_PER_SIDE + 1);
   localparam logic [AW-1:0] ENT1_A  = AW'((GSIDE - 1) * GSIDE + CELLS_PER_SIDE - 1);
   localparam logic [RW-1:0] LAST_RC = RW'(GSIDE - 1);
   localparam logic [MW-1:0] MERGE_INIT = MW'(CELLS_PER_SIDE * CELLS_PER_SIDE - 1);
   localparam logic [MW-1:0] MERGE_ONE  = MW'(1);
   localparam logic [LW-1:0] PATH_L  = LW'(PATH_CODE);
   localparam logic [LW-1:0] WALL_L  = LW'(WALL_CODE);
   localparam logic [LW-1:0] FIRST_L = LW'(FIRST_LABEL);

   state_type state_ff, state_in;

   logic [AW-1:0] idx_ff;
   logic [RW-1:0] row_ff, col_ff;
   logic [LW-1:0] label_ff;
   logic [MW-1:0] merges_ff;
   logic          entr_open_ff;
   logic [RW-1:0] own_r_ff, own_c_ff, oth_r_ff, oth_c_ff;
   logic [RW-1:0] wall_r_ff, wall_c_ff, rd_r_ff, rd_c_ff;
   logic [LW-1:0] own_lbl_ff, oth_lbl_ff;
   logic          carved_ff, wall_ff;
   logic [ENTRY_W-1:0] value_ff;
   logic          scan_pend_ff;
   logic [AW-1:0] scan_addr_ff;

   logic               rsp_valid_ff;
   logic               rsp_carved_ff, rsp_done_ff, rsp_wall_ff;
   logic [REMAIN_W-1:0] rsp_remain_ff;
   logic [ENTRY_W-1:0] rsp_value_ff;

   logic          accept;
   logic          carve_ok, dir_ok, rd_in_range;
   logic [3:0]    nbr_r, nbr_c;
   logic [RW-1:0] addr_r, addr_c;
   logic [AW-1:0] grid_addr;
   logic [LW-1:0] cmp_ref;
   logic          lbl_match;
   logic          odd_cell;
   logic          rsp_free;

   assign accept   = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign odd_cell = row_ff[0] && col_ff[0];

   // Decode the neighbour cell and check that the step stays in the grid
   always_comb begin
      nbr_r  = {1'b0, req_cell_row};
      nbr_c  = {1'b0, req_cell_col};
      dir_ok = 1'b0;
      unique case (dir_type'(req_direction))
         DIR_ROW_PLUS: begin
            nbr_r  = 4'(req_cell_row) + 4'd1;
            dir_ok = (int'(req_cell_row) + 1) < CELLS_PER_SIDE;
         end
         DIR_COL_PLUS: begin
            nbr_c  = 4'(req_cell_col) + 4'd1;
            dir_ok = (int'(req_cell_col) + 1) < CELLS_PER_SIDE;
         end
         DIR_ROW_MINUS: begin
            nbr_r  = 4'(req_cell_row) - 4'd1;
            dir_ok = req_cell_row != '0;
         end
         DIR_COL_MINUS: begin
            nbr_c  = 4'(req_cell_col) - 4'd1;
            dir_ok = req_cell_col != '0;
         end
      endcase
   end

   assign carve_ok = (merges_ff != '0) && (int'(req_cell_row) < CELLS_PER_SIDE)
                     && (int'(req_cell_col) < CELLS_PER_SIDE) && dir_ok;
   assign rd_in_range = (int'(req_grid_row) < GSIDE) && (int'(req_grid_col) < GSIDE);

   // Shared address unit: row * GSIDE + col for whichever entry this state needs
   always_comb begin
      unique case (state_ff)
         ST_RD_OWN: begin
            addr_r = own_r_ff;
            addr_c = own_c_ff;
         end
         ST_RD_OTHER: begin
            addr_r = oth_r_ff;
            addr_c = oth_c_ff;
         end
         ST_WALL: begin
            addr_r = wall_r_ff;
            addr_c = wall_c_ff;
         end
         default: begin
            addr_r = rd_r_ff;
            addr_c = rd_c_ff;
         end
      endcase
      grid_addr = AW'(AW'(addr_r) * GSIDE_A + AW'(addr_c));
   end

   // Shared label comparator: own against other, then other against every entry
   assign cmp_ref   = (state_ff == ST_SCAN) ? oth_lbl_ff : own_lbl_ff;
   assign lbl_match = ram_rd_data == cmp_ref;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (idx_ff == LAST_A) state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  ACT_INIT:  state_in = ST_INIT;
                  ACT_CARVE: state_in = carve_ok ? ST_RD_OWN : ST_RESP;
                  ACT_READ:  state_in = rd_in_range ? ST_RD_ENTRY : ST_RESP;
                  default:   state_in = ST_RESP;
               endcase
            end
         end
         ST_INIT:     if (idx_ff == LAST_A) state_in = ST_RESP;
         ST_RD_OWN:   state_in = ST_RD_OTHER;
         ST_RD_OTHER: state_in = ST_CMP;
         ST_CMP:      state_in = lbl_match ? ST_RESP : ST_WALL;
         ST_WALL:     state_in = ST_SCAN;
         ST_SCAN: begin
            if (idx_ff == NENT_A) begin
               state_in = (merges_ff == MERGE_ONE) ? ST_ENT0 : ST_RESP;
            end
         end
         ST_ENT0:     state_in = ST_ENT1;
         ST_ENT1:     state_in = ST_RESP;
         ST_RD_ENTRY: state_in = ST_RD_CAP;
         ST_RD_CAP:   state_in = ST_RESP;
         ST_RESP:     if (rsp_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Outputs: handshake and grid store port
   always_comb begin
      req_ready   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff;
      ram_wr_data = PATH_L;
      ram_rd_addr = idx_ff;
      unique case (state_ff)
         ST_CLEAR: ram_wr_en = 1'b1;
         ST_IDLE:  req_ready = 1'b1;
         ST_INIT: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = odd_cell ? label_ff : WALL_L;
         end
         ST_RD_OWN, ST_RD_OTHER, ST_RD_ENTRY: ram_rd_addr = grid_addr;
         ST_WALL: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = grid_addr;
         end
         ST_SCAN: begin
            ram_wr_en   = scan_pend_ff && lbl_match;
            ram_wr_addr = scan_addr_ff;
            ram_wr_data = own_lbl_ff;
         end
         ST_ENT0: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ENT0_A;
         end
         ST_ENT1: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ENT1_A;
         end
         default: ;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         merges_ff    <= '0;
         entr_open_ff <= 1'b1;
         scan_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_pend_ff <= (state_ff == ST_SCAN) && (idx_ff != NENT_A);

         // hold the response word until taken
         if (state_ff == ST_RESP && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_CLEAR: idx_ff <= (idx_ff == LAST_A) ? '0 : idx_ff + 1'b1;
            ST_IDLE:  idx_ff <= '0;
            ST_INIT: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == LAST_A) begin
                  merges_ff    <= MERGE_INIT;
                  entr_open_ff <= 1'b0;
               end
            end
            ST_SCAN: begin
               if (idx_ff != NENT_A) begin
                  idx_ff <= idx_ff + 1'b1;
               end else begin
                  merges_ff <= merges_ff - 1'b1;
                  if (merges_ff == MERGE_ONE) entr_open_ff <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      scan_addr_ff <= idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            row_ff   <= '0;
            col_ff   <= '0;
            label_ff <= FIRST_L;
            if (accept) begin
               carved_ff <= 1'b0;
               value_ff  <= '0;
               wall_ff   <= 1'b0;
               own_r_ff  <= RW'({req_cell_row, 1'b1});
               own_c_ff  <= RW'({req_cell_col, 1'b1});
               oth_r_ff  <= RW'({nbr_r, 1'b1});
               oth_c_ff  <= RW'({nbr_c, 1'b1});
               wall_r_ff <= RW'(5'(req_cell_row) + 5'(nbr_r) + 5'd1);
               wall_c_ff <= RW'(5'(req_cell_col) + 5'(nbr_c) + 5'd1);
               rd_r_ff   <= RW'(req_grid_row);
               rd_c_ff   <= RW'(req_grid_col);
            end
         end
         ST_INIT: begin
            // advance row-major, labelling odd cells
            if (odd_cell) label_ff <= label_ff + 1'b1;
            if (col_ff == LAST_RC) begin
               col_ff <= '0;
               row_ff <= row_ff + 1'b1;
            end else begin
               col_ff <= col_ff + 1'b1;
            end
         end
         ST_RD_OTHER: own_lbl_ff <= ram_rd_data;
         ST_CMP:      oth_lbl_ff <= ram_rd_data;
         ST_SCAN:     if (idx_ff == NENT_A) carved_ff <= 1'b1;
         ST_RD_CAP: begin
            value_ff <= ENTRY_W'(ram_rd_data);
            wall_ff  <= ram_rd_data == WALL_L;
         end
         default: ;
      endcase

      // load the response word
      if (state_ff == ST_RESP && rsp_free) begin
         rsp_carved_ff <= carved_ff;
         rsp_remain_ff <= REMAIN_W'(merges_ff);
         rsp_done_ff   <= (merges_ff == '0) && entr_open_ff;
         rsp_value_ff  <= value_ff;
         rsp_wall_ff   <= wall_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_carved      = rsp_carved_ff;
   assign rsp_remaining   = rsp_remain_ff;
   assign rsp_done_res    = rsp_done_ff;
   assign rsp_entry_value = rsp_value_ff;
   assign rsp_is_wall     = rsp_wall_ff;

endmodule

@@ rtl/core/maze_carver_set_merge_top.sv @@
// Maze carver by set merging: top level, word packing and grid store.
// Depends on mcsm_pkg, mcsm_ctrl and mcsm_grid_ram.
//
// Usage: each request word carries an action in req_tuser (initialise grid,
// carve attempt, read one entry); every request gives exactly one response word.
// A carve joins the labelled sets of two neighbouring cells by opening the wall
// between them; once the last merge is made both entrances open.
// Initialisation and each carve that merges two sets sweep the whole grid store
// of (2N+1)^2 entries (N = CELLS_PER_SIDE, 289 entries by default); a rejected
// carve, a read outside the grid and the unused action code answer without one.
// One request is in flight at a time; req_tready is high only while idle.
// After reset the store is swept to zero with req_tready low.
// The response sits in an output register: a stalled receiver holds rsp_tvalid
// and rsp_tdata, and the next request is still accepted while it waits.
module maze_carver_set_merge_top #(
   parameter int CELLS_PER_SIDE = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // cell_row[2:0], cell_col[5:3], direction[7:6], grid_row[12:8], grid_col[17:13]
   input  logic [mcsm_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // action[1:0]
   input  logic [mcsm_pkg::REQ_TUSER_W-1:0]   req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // carved[0], remaining[6:1], done_res[7], entry_value[14:8], is_wall[15]
   output logic [mcsm_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import mcsm_pkg::*;

   localparam int GSIDE = 2 * CELLS_PER_SIDE + 1;
   localparam int NENT  = GSIDE * GSIDE;
   localparam int AW    = $clog2(NENT + 1);
   localparam int LW    = $clog2(CELLS_PER_SIDE * CELLS_PER_SIDE + 2);

   logic                carved, done_res, is_wall;
   logic [REMAIN_W-1:0] remaining;
   logic [ENTRY_W-1:0]  entry_value;
   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr, ram_rd_addr;
   logic [LW-1:0]       ram_wr_data, ram_rd_data;

   mcsm_ctrl #(
      .CELLS_PER_SIDE (CELLS_PER_SIDE),
      .AW             (AW),
      .LW             (LW)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_tvalid),
      .req_ready       (req_tready),
      .req_action      (req_tuser[1:0]),
      .req_cell_row    (req_tdata[2:0]),
      .req_cell_col    (req_tdata[5:3]),
      .req_direction   (req_tdata[7:6]),
      .req_grid_row    (req_tdata[12:8]),
      .req_grid_col    (req_tdata[17:13]),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_carved      (carved),
      .rsp_remaining   (remaining),
      .rsp_done_res    (done_res),
      .rsp_entry_value (entry_value),
      .rsp_is_wall     (is_wall),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data)
   );

   mcsm_grid_ram #(
      .DEPTH (NENT),
      .AW    (AW),
      .LW    (LW)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Pack the response word, first field lowest
   assign rsp_tdata = {is_wall, entry_value, done_res, remaining, carved};

endmodule

@@ verif/maze_carver_set_merge_top_tb.sv @@
// Self-checking bench for maze_carver_set_merge_top: drives request words, predicts each
// response from its own grid shadow and compares every returned word field by field.
// Depends on mcsm_pkg and the RTL of maze_carver_set_merge_top.
`timescale 1ns / 1ps

module maze_carver_set_merge_top_tb;
   import mcsm_pkg::*;

   localparam int N              = 8;
   localparam int GSIDE          = 2 * N + 1;
   localparam int GCOUNT         = GSIDE * GSIDE;
   localparam int EDGE_COUNT     = 2 * N * (N - 1);
   localparam int RSP_HOLD_CYCLES = 3000;
   localparam int HOLD_AT_RESULT = 60;
   localparam int WATCHDOG_LIMIT = 12000;
   localparam int SETTLE_CYCLES  = 320;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   typedef struct {
      logic [1:0] action;
      logic [2:0] cell_row;
      logic [2:0] cell_col;
      dir_type    dir;
      logic [4:0] grid_row;
      logic [4:0] grid_col;
      bit         drain;
   } maze_request_type;

   typedef struct {
      logic       carved;
      logic [5:0] remaining;
      logic       done;
      logic [6:0] entry;
      logic       wall;
   } maze_outcome_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // Grid shadow and merge count
   logic [6:0] shadow_grid [GCOUNT];
   logic [5:0] shadow_merges;

   maze_request_type request_backlog[$];
   maze_outcome_type expected_outcomes[$];
   maze_request_type req_in_flight;
   maze_outcome_type want;

   int  edge_pool [EDGE_COUNT];
   int  error_count = 0;
   int  n_results = 0;
   int  send_gap = 0;
   int  send_calm = 0;
   int  stall_left = 0;
   int  recv_calm = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   bit  offer_next;
   bit  ready_next;
   int  quiet_cycles = 0;

   maze_carver_set_merge_top #(.CELLS_PER_SIDE(N)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial forever #1 clock = ~clock;

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic int cell_index(int r, int c);
      return r * GSIDE + c;
   endfunction

   // Apply one request to the shadow grid and return the response it must give
   function automatic maze_outcome_type apply_maze_request(maze_request_type rq);
      maze_outcome_type res;
      int         r, c, k, label, cr, cc, nr, nc;
      logic [6:0] own, other;
      bit         ok;
      res.carved = 1'b0;
      res.entry  = '0;
      res.wall   = 1'b0;
      cr = int'(rq.cell_row);
      cc = int'(rq.cell_col);
      nr = cr;
      nc = cc;
      ok = 1'b1;
      case (rq.action)
         ACT_INIT: begin
            label = FIRST_LABEL;
            for (r = 0; r < GSIDE; r++) begin
               for (c = 0; c < GSIDE; c++) begin
                  if (r % 2 == 0 || c % 2 == 0) begin
                     shadow_grid[cell_index(r, c)] = 7'(WALL_CODE);
                  end else begin
                     shadow_grid[cell_index(r, c)] = 7'(label);
                     label++;
                  end
               end
            end
            shadow_merges = 6'(N * N - 1);
         end
         ACT_CARVE: if (shadow_merges != 0) begin
            if (cr >= N || cc >= N) ok = 1'b0;
            case (rq.dir)
               DIR_ROW_PLUS:  if (cr + 1 >= N) ok = 1'b0; else nr = cr + 1;
               DIR_COL_PLUS:  if (cc + 1 >= N) ok = 1'b0; else nc = cc + 1;
               DIR_ROW_MINUS: if (cr == 0) ok = 1'b0; else nr = cr - 1;
               default:       if (cc == 0) ok = 1'b0; else nc = cc - 1;
            endcase
            if (ok) begin
               own   = shadow_grid[cell_index(2 * cr + 1, 2 * cc + 1)];
               other = shadow_grid[cell_index(2 * nr + 1, 2 * nc + 1)];
               if (own != other) begin
                  // open the wall, then fold the neighbour's set into ours
                  shadow_grid[cell_index(cr + nr + 1, cc + nc + 1)] = 7'(PATH_CODE);
                  for (k = 0; k < GCOUNT; k++)
                     if (shadow_grid[k] == other) shadow_grid[k] = own;
                  shadow_merges = shadow_merges - 6'd1;
                  if (shadow_merges == 0) begin
                     shadow_grid[cell_index(0, N + 1)]         = 7'(PATH_CODE);
                     shadow_grid[cell_index(GSIDE - 1, N - 1)] = 7'(PATH_CODE);
                  end
                  res.carved = 1'b1;
               end
            end
         end
         ACT_READ: if (rq.grid_row < GSIDE && rq.grid_col < GSIDE) begin
            res.entry = shadow_grid[cell_index(int'(rq.grid_row), int'(rq.grid_col))];
            res.wall  = (res.entry == WALL_CODE);
         end
         default: ;
      endcase
      res.remaining = shadow_merges;
      res.done = (shadow_merges == 0) &&
                 (shadow_grid[cell_index(0, N + 1)] == PATH_CODE) &&
                 (shadow_grid[cell_index(GSIDE - 1, N - 1)] == PATH_CODE);
      return res;
   endfunction

   // Idle length: mostly short, a few long, with occasional calm stretches
   function automatic int idle_length(inout int calm);
      int pick;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      if (pick < 50) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 120);
   endfunction

   task automatic queue_request(logic [1:0] act, int cr, int cc, int dir, int gr, int gc);
      maze_request_type rq;
      rq.action   = act;
      rq.cell_row = 3'(cr);
      rq.cell_col = 3'(cc);
      rq.dir      = dir_type'(dir[1:0]);
      rq.grid_row = 5'(gr);
      rq.grid_col = 5'(gc);
      rq.drain    = 1'b0;
      request_backlog.push_back(rq);
   endtask

   task automatic queue_carve(int cr, int cc, dir_type dir);
      queue_request(ACT_CARVE, cr, cc, dir, $urandom_range(0, 31), $urandom_range(0, 31));
   endtask

   task automatic queue_read(int gr, int gc);
      queue_request(ACT_READ, $urandom_range(0, 7), $urandom_range(0, 7),
                    $urandom_range(0, 3), gr, gc);
   endtask

   task automatic queue_noise(logic [1:0] act);
      queue_request(act, $urandom_range(0, 7), $urandom_range(0, 7),
                    $urandom_range(0, 3), $urandom_range(0, 31), $urandom_range(0, 31));
   endtask

   // Init, then carve across shuffled cell edges, each from a random side,
   // with in-grid reads mixed in; a full edge list always finishes the maze
   task automatic queue_maze(int n_edges, int read_pct);
      int i, j, tmp, r, c;
      queue_noise(ACT_INIT);
      k_fill: for (i = 0; i < EDGE_COUNT; i++) edge_pool[i] = i;
      for (i = EDGE_COUNT - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = edge_pool[i];
         edge_pool[i] = edge_pool[j];
         edge_pool[j] = tmp;
      end
      for (i = 0; i < n_edges; i++) begin
         if ($urandom_range(0, 99) < read_pct)
            queue_read($urandom_range(0, GSIDE - 1), $urandom_range(0, GSIDE - 1));
         if (edge_pool[i] < N * (N - 1)) begin
            // horizontal neighbours (r, c) and (r, c+1)
            r = edge_pool[i] / (N - 1);
            c = edge_pool[i] % (N - 1);
            if ($urandom_range(0, 1)) queue_carve(r, c, DIR_COL_PLUS);
            else queue_carve(r, c + 1, DIR_COL_MINUS);
         end else begin
            // vertical neighbours (r, c) and (r+1, c)
            r = (edge_pool[i] - N * (N - 1)) / N;
            c = (edge_pool[i] - N * (N - 1)) % N;
            if ($urandom_range(0, 1)) queue_carve(r, c, DIR_ROW_PLUS);
            else queue_carve(r + 1, c, DIR_ROW_MINUS);
         end
      end
      queue_read(0, N + 1);
      queue_read(GSIDE - 1, N - 1);
      queue_noise(ACT_CARVE);
   endtask

   task automatic compare_field(string label, int expected_val, int actual_val);
      if (expected_val != actual_val) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d",
                  $time, label, expected_val, actual_val);
      end
   endtask

   // Request driver: offer backlog words, idle between them, hold for a drain
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         offer_next = req_tvalid;
         if (req_tvalid && req_tready) begin
            expected_outcomes.push_back(apply_maze_request(req_in_flight));
            offer_next = 1'b0;
            send_gap = idle_length(send_calm);
         end
         if (!offer_next) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (request_backlog.size() > 0 &&
                         !(request_backlog[0].drain && expected_outcomes.size() != 0)) begin
               req_in_flight = request_backlog.pop_front();
               req_tdata <= {6'b0, req_in_flight.grid_col, req_in_flight.grid_row,
                             req_in_flight.dir, req_in_flight.cell_col,
                             req_in_flight.cell_row};
               req_tuser <= req_in_flight.action;
               offer_next = 1'b1;
            end
         end
         req_tvalid <= offer_next;
      end
   end

   // Response monitor: check each word, stall at random, one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            n_results++;
            if (expected_outcomes.size() == 0) begin
               error_count++;
               $display("%0t: response word mismatch, expected none, actual %h",
                        $time, rsp_tdata);
            end else begin
               want = expected_outcomes.pop_front();
               compare_field("carved", want.carved, rsp_tdata[0]);
               compare_field("remaining", want.remaining, rsp_tdata[6:1]);
               compare_field("done_res", want.done, rsp_tdata[7]);
               compare_field("entry_value", want.entry, rsp_tdata[14:8]);
               compare_field("is_wall", want.wall, rsp_tdata[15]);
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (!hold_done && n_results == HOLD_AT_RESULT) begin
            hold_done = 1'b1;
            hold_left = RSP_HOLD_CYCLES;
            ready_next = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
         end else begin
            if ($urandom_range(0, 99) < 25) stall_left = idle_length(recv_calm);
            ready_next = (stall_left == 0);
         end
         rsp_tready <= ready_next;
      end
   end

   // Watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
         $display("[maze_carver_set_merge_top] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int k = 0; k < GCOUNT; k++) shadow_grid[k] = 7'(PATH_CODE);
      shadow_merges = '0;

      // Directed: state after reset, unused code, grid corners, edge moves
      queue_read(0, 0);
      queue_carve(0, 0, DIR_ROW_PLUS);
      queue_noise(ACT_UNUSED);
      queue_noise(ACT_INIT);
      queue_read(1, 1);
      queue_read(GSIDE - 2, GSIDE - 2);
      queue_read(GSIDE - 1, GSIDE - 1);
      queue_read(31, 31);
      queue_read(17, 0);
      queue_read(0, N + 1);
      queue_carve(0, 0, DIR_ROW_MINUS);
      queue_carve(0, 0, DIR_COL_MINUS);
      queue_carve(7, 7, DIR_ROW_PLUS);
      queue_carve(7, 7, DIR_COL_PLUS);
      queue_carve(0, 0, DIR_COL_PLUS);
      queue_carve(0, 1, DIR_COL_MINUS);
      queue_carve(7, 7, DIR_ROW_MINUS);
      queue_carve(7, 7, DIR_COL_MINUS);
      queue_read(1, 2);
      queue_read(1, 3);
      queue_read(GSIDE - 3, GSIDE - 2);
      queue_noise(ACT_UNUSED);

      // Random: full maze, noise, partial maze, full maze
      queue_maze(EDGE_COUNT, 15);
      for (int k = 0; k < 60; k++) begin
         case ($urandom_range(0, 19))
            0:                queue_noise(ACT_INIT);
            1, 2:             queue_noise(ACT_UNUSED);
            3, 4, 5, 6, 7, 8: queue_noise(ACT_READ);
            default:          queue_noise(ACT_CARVE);
         endcase
         if (k == 0) request_backlog[request_backlog.size() - 1].drain = 1'b1;
      end
      queue_maze(50, 15);
      queue_maze(EDGE_COUNT, 20);

      while (reset || request_backlog.size() != 0 || req_tvalid ||
             expected_outcomes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[maze_carver_set_merge_top] OK");
      end else begin
         $display("[maze_carver_set_merge_top] ERROR");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/mcsm_pkg.sv
rtl/core/mcsm_grid_ram.sv
rtl/core/mcsm_ctrl.sv
rtl/core/maze_carver_set_merge_top.sv
verif/maze_carver_set_merge_top_tb.sv
